// ----- sv/iss_pkg.sv -----
// Shared constants and types for the insertion sorter.
package iss_pkg;

  localparam int CAPACITY = 32;
  localparam int VALUE_W  = 32;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic                      valid;
    logic                      gt;
    logic signed [VALUE_W-1:0] value;
  } cell_link_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic insert;
    logic shift_out;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } sorter_state_t;

endpackage

// ----- sv/iss_cell.sv -----
// One cell of the insertion chain: holds a single sorted value.
module iss_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  iss_pkg::cell_ctl_t                ctl,
  input  logic signed [iss_pkg::VALUE_W-1:0] sample,
  input  iss_pkg::cell_link_t               left,
  input  iss_pkg::cell_link_t               right,
  output iss_pkg::cell_link_t               own
);
  import iss_pkg::*;

  logic                      valid;
  logic signed [VALUE_W-1:0] value;
  logic                      gt;

  // Strictly greater keeps equal values in arrival order.
  assign gt  = valid && (value > sample);
  assign own = '{valid: valid, gt: gt, value: value};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift_out) begin
      valid <= right.valid;
      value <= right.value;
    end else if (ctl.insert) begin
      if (left.gt) begin
        // The new value lands to our left, so everything here moves up one.
        valid <= 1'b1;
        value <= left.value;
      end else if (gt || (!valid && left.valid)) begin
        valid <= 1'b1;
        value <= sample;
      end
    end
  end

endmodule

// ----- sv/insertion_sorter_unit.sv -----
// Top level of the insertion sorter: a chain of sorting cells and the batch control.
// Loading takes one input transaction per cycle; each value is placed in the cell chain in
// the cycle it is accepted, by a compare in every cell against the broadcast value.
// After the batch-end transaction the first result is valid in the next cycle, then one result
// per cycle while m_tready is high; a batch blocks input until its last stored result is taken.
// Reset clears the cell valid bits, the drop flag and the control state; there is no sweep.
module insertion_sorter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [31:0] sample_value
  input  logic        s_tlast,  // batch_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // [31:0] sorted_value
  output logic        m_tlast,  // final_result
  output logic        m_tuser   // [0] overflow
);
  import iss_pkg::*;

  sorter_state_t state;
  sorter_state_t state_next;
  logic          dropped;

  cell_link_t    links [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  cell_ctl_t     ctl;
  logic          full;
  logic          s_fire;
  logic          m_fire;

  localparam cell_link_t EDGE_LEFT  = '{valid: 1'b1, gt: 1'b0, value: '0};
  localparam cell_link_t EDGE_RIGHT = '{valid: 1'b0, gt: 1'b0, value: '0};

  assign s_tready = (state == ST_LOAD);
  assign s_fire   = s_tvalid && s_tready;
  assign m_fire   = m_tvalid && m_tready;
  assign full     = cell_valid[CAPACITY-1];

  assign ctl.insert    = s_fire && !full;
  assign ctl.shift_out = m_fire;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      iss_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .ctl    (ctl),
        .sample (signed'(s_tdata)),
        .left   ((i == 0) ? EDGE_LEFT : links[(i == 0) ? 0 : i - 1]),
        .right  ((i == CAPACITY - 1) ? EDGE_RIGHT : links[(i == CAPACITY - 1) ? i : i + 1]),
        .own    (links[i])
      );
      assign cell_valid[i] = links[i].valid;
    end
  endgenerate

  // The head of the chain is the smallest value; unloading shifts toward it.
  assign m_tvalid = (state == ST_DRAIN) && cell_valid[0];
  assign m_tdata  = links[0].value;
  assign m_tlast  = !cell_valid[1];
  assign m_tuser  = dropped;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (s_fire && s_tlast) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if ((m_fire && m_tlast) || !cell_valid[0]) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      dropped <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DRAIN && state_next == ST_LOAD) begin
        dropped <= 1'b0;
      end else if (s_fire && full) begin
        dropped <= 1'b1;
      end
    end
  end

  // Occupied cells always form a prefix of the chain.
  assert property (@(posedge clk) disable iff (rst)
    (cell_valid & (cell_valid + 1'b1)) == '0)
    else $error("cell valid bits are not a prefix");

  // Input and output never run at the same time.
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !s_tready)
    else $error("output valid while accepting input");

  // A batch end always produces at least one result in the next cycle.
  assert property (@(posedge clk) disable iff (rst) (s_fire && s_tlast) |=> m_tvalid)
    else $error("batch end without results");

  // Results come out in ascending order.
  assert property (@(posedge clk) disable iff (rst)
    (m_fire && !m_tlast) |=> (m_tvalid && ($signed(m_tdata) >= $signed($past(m_tdata)))))
    else $error("results out of order");

  // After the final result the block is ready for the next batch.
  assert property (@(posedge clk) disable iff (rst) (m_fire && m_tlast) |=> s_tready)
    else $error("not ready after final result");

endmodule

// ----- sim/insertion_sorter_unit_tb.sv -----
// Self-checking testbench for insertion_sorter_unit: directed and random batches checked by a sorting scoreboard.
module insertion_sorter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iss_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 20;

  typedef logic signed [VALUE_W-1:0] sample_t;

  typedef struct {
    sample_t value;
    logic    fin;
    logic    ovf;
  } sorted_result_t;

  // Keeps its own sorted copy of the batch and the results it must produce.
  class sort_scoreboard;
    sample_t        held[$];
    logic           dropped = 1'b0;
    sorted_result_t expected_q[$];
    int             errors = 0;

    function void add_sample(sample_t value, logic last);
      int pos;
      sorted_result_t res;
      if (held.size() >= CAPACITY) begin
        dropped = 1'b1;
      end else begin
        pos = held.size();
        // Stop at an equal value so the new one lands after it.
        while (pos > 0 && held[pos-1] > value) pos--;
        held.insert(pos, value);
      end
      if (last) begin
        foreach (held[k]) begin
          res.value = held[k];
          res.fin   = (k == held.size() - 1);
          res.ovf   = dropped;
          expected_q.insert(expected_q.size(), res);
        end
        held.delete();
        dropped = 1'b0;
      end
    endfunction

    function void check_result(sample_t value, logic fin, logic ovf);
      sorted_result_t want;
      if (expected_q.size() == 0) begin
        $error("sorted result %0d arrived with nothing expected", value);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (value !== want.value) begin
        $error("sorted_value: expected %0d, got %0d", want.value, value);
        errors++;
      end
      if (fin !== want.fin) begin
        $error("final_result: expected %0b, got %0b", want.fin, fin);
        errors++;
      end
      if (ovf !== want.ovf) begin
        $error("overflow: expected %0b, got %0b", want.ovf, ovf);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] sample_value
  logic        s_tlast = 1'b0; // batch_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] sorted_value
  logic        m_tlast;        // final_result
  logic        m_tuser;        // [0] overflow

  sort_scoreboard sb = new();
  logic           hold_request = 1'b0;
  logic           steady = 1'b0;
  int             idle_cycles = 0;

  insertion_sorter_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.add_sample(sample_t'(s_tdata), s_tlast);
    if (!rst && m_tvalid && m_tready) sb.check_result(sample_t'(m_tdata), m_tlast, m_tuser);
  end

  // Watchdog: any transaction on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("insertion_sorter_unit verification failed");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom;
    // A narrow range produces plenty of equal values.
    if (r < 8) return 32'($signed($urandom_range(0, 8)) - 4);
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Returns just after the rising edge at which the transaction was taken.
  task automatic send_sample(input logic [31:0] value, input logic last);
    int gap;
    @(negedge clk);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_batch(input int count);
    for (int i = 0; i < count; i++) send_sample(pick_value(), i == count - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Receiver: random ready pattern, a long hold when asked, always ready when steady.
  initial begin
    int n;
    int r;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        n = HOLD_CYCLES;
      end else if (steady) begin
        m_tready <= 1'b1;
        n = 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          m_tready <= 1'b1;
          n = $urandom_range(1, 12);
        end else begin
          m_tready <= 1'b0;
          n = (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 30);
        end
      end
      repeat (n) @(negedge clk);
    end
  end

  initial begin
    int count;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A batch of one value.
    send_sample(32'h8000_0000, 1'b1);
    // Extremes, duplicates and alternating bit patterns.
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0001, 1'b0);
    send_sample(32'h0000_0005, 1'b0);
    send_sample(32'h0000_0005, 1'b0);
    send_sample(32'hAAAA_AAAA, 1'b0);
    send_sample(32'h5555_5555, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b1);
    // Descending input, the worst case for the insertion.
    for (int i = 4; i >= 0; i--) send_sample(32'(i), i == 0);

    for (int b = 0; b < 14; b++) begin
      case (b)
        5: count = CAPACITY;      // exactly full, no overflow
        8: count = CAPACITY + 3;  // several drops, the batch-end value among them
        default: count = $urandom_range(1, 2);
      endcase
      if (b == 4) begin
        // Output stalls for a long time while more batches are offered.
        hold_request = 1'b1;
        send_batch(6);
        send_batch(4);
      end
      if (b == 9) wait_drained();
      steady = (b >= 10 && b <= 12);
      send_batch(count);
    end
    steady = 1'b0;

    wait_drained();
    if (sb.errors == 0) begin
      $display("insertion_sorter_unit verification clean");
    end else begin
      $display("insertion_sorter_unit verification failed");
    end
    $finish;
  end

endmodule
